>>> hdl/bank_switch_scanline_irq_mapper_top_defines.svh
// Assertion macros used by the mapper top module.
`ifndef BANK_SWITCH_SCANLINE_IRQ_MAPPER_TOP_DEFINES_SVH
`define BANK_SWITCH_SCANLINE_IRQ_MAPPER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BSSIM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSSIM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/bssim_pkg.sv
package bssim_pkg;

  // item kinds
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_PRG   = 2'd2;
  localparam logic [1:0] ACT_CHR   = 2'd3;

  // register decode on {addr[15:13], addr[0]}
  localparam logic [3:0] REG_BANK_SELECT = 4'b1000;
  localparam logic [3:0] REG_BANK_DATA   = 4'b1001;
  localparam logic [3:0] REG_MIRROR      = 4'b1010;
  localparam logic [3:0] REG_PRG_RAM     = 4'b1011;
  localparam logic [3:0] REG_IRQ_LATCH   = 4'b1100;
  localparam logic [3:0] REG_IRQ_RELOAD  = 4'b1101;
  localparam logic [3:0] REG_IRQ_DISABLE = 4'b1110;
  localparam logic [3:0] REG_IRQ_ENABLE  = 4'b1111;

  // configuration register indexes
  localparam logic CFG_PRG_LOG2 = 1'b0;
  localparam logic CFG_CHR_LOG2 = 1'b1;

  localparam logic [2:0] PRG_LOG2_MAX = 3'd6;
  localparam logic [3:0] CHR_LOG2_MAX = 4'd8;

  typedef logic [7:0][7:0] bank_file_t;

  typedef struct packed {
    logic       prg_swap;
    logic       chr_swap;
    logic [2:0] prg_log2;
    logic [3:0] chr_log2;
  } map_cfg_t;

endpackage

>>> hdl/bssim_translate.sv
module bssim_translate (
  input  logic [1:0]            action,
  input  logic [15:0]           addr,
  input  bssim_pkg::map_cfg_t   cfg,
  input  bssim_pkg::bank_file_t bank_values,
  output logic [18:0]           mapped_address
);
  import bssim_pkg::*;

  logic [2:0] prg_n;
  logic [5:0] prg_mask;
  logic [3:0] chr_n;
  logic [7:0] chr_mask;
  logic [1:0] slot;
  logic       pat_hi;
  logic [2:0] rd_idx;
  logic [7:0] rd_bank;
  logic [5:0] prg_bank;
  logic [7:0] chr_bank;

  always_comb begin
    prg_n    = (cfg.prg_log2 > PRG_LOG2_MAX) ? PRG_LOG2_MAX : cfg.prg_log2;
    prg_mask = 6'((7'd1 << prg_n) - 7'd1);
    chr_n    = (cfg.chr_log2 > CHR_LOG2_MAX) ? CHR_LOG2_MAX : cfg.chr_log2;
    chr_mask = 8'((9'd1 << chr_n) - 9'd1);
    slot     = addr[14:13];
    pat_hi   = addr[12] ^ cfg.chr_swap;

    // single read port into the bank file
    if (action == ACT_PRG) begin
      rd_idx = (slot == 2'd1) ? 3'd7 : 3'd6;
    end else if (!pat_hi) begin
      rd_idx = {2'b00, addr[11]};
    end else begin
      rd_idx = 3'd2 + {1'b0, addr[11:10]};
    end
    rd_bank = bank_values[rd_idx];

    if (slot == 2'd1) begin
      prg_bank = rd_bank[5:0];
    end else if (slot == 2'd3) begin
      prg_bank = prg_mask;
    end else if ((slot == 2'd0) != cfg.prg_swap) begin
      prg_bank = rd_bank[5:0];
    end else begin
      prg_bank = prg_mask - 6'd1;
    end

    // 2 KB windows drop bank bit 0 and use address bit 10
    chr_bank = pat_hi ? rd_bank : {rd_bank[7:1], addr[10]};

    case (action)
      ACT_PRG: mapped_address = addr[15] ? {prg_bank & prg_mask, addr[12:0]} : 19'd0;
      ACT_CHR: mapped_address = {1'b0, chr_bank & chr_mask, addr[9:0]};
      default: mapped_address = 19'd0;
    endcase
  end

endmodule

>>> hdl/bank_switch_scanline_irq_mapper_top.sv
// Bank-switching cartridge mapper with scanline IRQ counter.
// Input channel (in_valid/in_stall) carries one transaction per item:
// action selects a register write, a scanline tick, a program-space
// translate or a pattern-space translate; addr and data go with it.
// Output channel (out_valid/out_stall) returns one result per item:
// mapped_address (zero for writes and ticks), irq_line and
// horizontal_mirror, all as they stand after that item.
// Each item passes the input register, then the result register.
// Throughput: one item per cycle while out_stall is low, set by the single
// combinational pass from the input register to the result register.
// When out_stall is high and the result register is full, a full input
// register holds and in_stall rises; with a free result register the
// input side keeps flowing.
// cfg_write/cfg_index/cfg_data set the ROM size registers; write them
// only while the block is idle.
// Reset (rst, synchronous): pipeline empty, all mapper state cleared,
// size registers back to 4 program and 8 pattern banks.
module bank_switch_scanline_irq_mapper_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [15:0] addr,
  input  logic [7:0]  data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [18:0] mapped_address,
  output logic        irq_line,
  output logic        horizontal_mirror
);
  import bssim_pkg::*;
  `include "bank_switch_scanline_irq_mapper_top_defines.svh"

  // size registers
  logic [2:0] prg_log2;
  logic [3:0] chr_log2;

  // input register
  logic        s1_valid;
  logic [1:0]  s1_action;
  logic [15:0] s1_addr;
  logic [7:0]  s1_data;

  // mapper state
  logic [7:0] bank_select, bank_select_next;
  bank_file_t bank_values, bank_values_next;
  logic       mirror_mode, mirror_mode_next;
  logic [7:0] reload_value, reload_value_next;
  logic [7:0] line_counter, line_counter_next;
  logic       irq_enable, irq_enable_next;
  logic       irq_pending, irq_pending_next;

  logic        out_free;
  logic        s1_fire;
  logic [3:0]  reg_code;
  logic [18:0] xlate_addr;
  map_cfg_t    map_cfg;

  // pipeline flow: result register frees when empty or being taken
  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_log2 <= 3'd2;
      chr_log2 <= 4'd3;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PRG_LOG2: prg_log2 <= cfg_data[2:0];
        CFG_CHR_LOG2: chr_log2 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_action <= action;
      s1_addr   <= addr;
      s1_data   <= data;
    end
  end

  // state update for the item in the input register
  assign reg_code = {s1_addr[15:13], s1_addr[0]};

  always_comb begin
    bank_select_next  = bank_select;
    bank_values_next  = bank_values;
    mirror_mode_next  = mirror_mode;
    reload_value_next = reload_value;
    line_counter_next = line_counter;
    irq_enable_next   = irq_enable;
    irq_pending_next  = irq_pending;
    if (s1_fire) begin
      case (s1_action)
        ACT_WRITE: begin
          unique case (reg_code)
            REG_BANK_SELECT: bank_select_next = s1_data;
            REG_BANK_DATA:   bank_values_next[bank_select[2:0]] = s1_data;
            REG_MIRROR:      mirror_mode_next = s1_data[0];
            REG_IRQ_LATCH:   reload_value_next = s1_data;
            REG_IRQ_RELOAD:  line_counter_next = 8'd0;
            REG_IRQ_DISABLE: begin
              irq_enable_next  = 1'b0;
              irq_pending_next = 1'b0;
            end
            REG_IRQ_ENABLE:  irq_enable_next = 1'b1;
            default: ;  // RAM protect and writes below 0x8000 ignored
          endcase
        end
        ACT_TICK: begin
          line_counter_next = (line_counter == 8'd0) ? reload_value
                                                     : line_counter - 8'd1;
          if (irq_enable && line_counter_next == 8'd0) begin
            irq_pending_next = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select  <= 8'd0;
      bank_values  <= '0;
      mirror_mode  <= 1'b0;
      reload_value <= 8'd0;
      line_counter <= 8'd0;
      irq_enable   <= 1'b0;
      irq_pending  <= 1'b0;
    end else begin
      bank_select  <= bank_select_next;
      bank_values  <= bank_values_next;
      mirror_mode  <= mirror_mode_next;
      reload_value <= reload_value_next;
      line_counter <= line_counter_next;
      irq_enable   <= irq_enable_next;
      irq_pending  <= irq_pending_next;
    end
  end

  // translation reads current state; queries never change it
  assign map_cfg = '{prg_swap: bank_select[6], chr_swap: bank_select[7],
                     prg_log2: prg_log2, chr_log2: chr_log2};

  bssim_translate u_translate (
    .action         (s1_action),
    .addr           (s1_addr),
    .cfg            (map_cfg),
    .bank_values    (bank_values),
    .mapped_address (xlate_addr)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      mapped_address    <= xlate_addr;
      irq_line          <= irq_pending_next;
      horizontal_mirror <= mirror_mode_next;
    end
  end

  `BSSIM_ASSERT_NOW(a_pending_needs_enable, irq_pending, irq_enable, "irq pending while disabled")
  `BSSIM_ASSERT_NEXT(a_tick_counts_down, s1_fire && s1_action == ACT_TICK && line_counter != 8'd0, line_counter == $past(line_counter) - 8'd1, "scanline counter did not count down")
  `BSSIM_ASSERT_NEXT(a_no_addr_on_ctrl, s1_fire && (s1_action == ACT_WRITE || s1_action == ACT_TICK), mapped_address == 19'd0, "write or tick produced an address")
  `BSSIM_ASSERT_NEXT(a_fire_loads_result, s1_fire, out_valid, "issued item did not reach result register")
  `BSSIM_ASSERT_NEXT(a_mirror_only_on_write, !(s1_fire && s1_action == ACT_WRITE), $stable(mirror_mode), "mirroring changed without a write")

endmodule

>>> tb/bank_switch_scanline_irq_mapper_top_tb.sv
module bank_switch_scanline_irq_mapper_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bssim_pkg::*;

  // Expected view of one result transaction.
  typedef struct packed {
    logic [18:0] rom_addr;
    logic        irq;
    logic        hmirror;
  } map_result_t;

  // DUT ports; every input has a known value from time zero.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = CFG_PRG_LOG2;
  logic [3:0]  cfg_data = 4'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = ACT_TICK;
  logic [15:0] addr = 16'h0000;
  logic [7:0]  data = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [18:0] mapped_address;
  logic        irq_line;
  logic        horizontal_mirror;

  bank_switch_scanline_irq_mapper_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .addr(addr),
    .data(data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .mapped_address(mapped_address),
    .irq_line(irq_line),
    .horizontal_mirror(horizontal_mirror)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Mapper shadow state, reset values. Size registers follow the DUT's
  // reset: 4 program banks, 8 pattern banks.
  // ---------------------------------------------------------------------
  logic [2:0] prg_log2 = 3'd2;
  logic [3:0] chr_log2 = 4'd3;
  logic [7:0] bank_sel = 8'h00;
  logic [7:0] bank_regs [8] = '{default: 8'h00};
  logic       mirror_h = 1'b0;
  logic [7:0] irq_reload = 8'h00;
  logic [7:0] scan_count = 8'h00;
  logic       irq_armed = 1'b0;
  logic       irq_flag = 1'b0;

  map_result_t pending_results[$];
  int          mismatch_count = 0;
  bit          no_gaps = 1'b0;   // when set, neither side idles

  // Applies one accepted input transaction to the shadow state and returns
  // the result the DUT must produce for it (state after the update).
  function automatic map_result_t map_and_update(input logic [1:0] act,
                                                 input logic [15:0] a,
                                                 input logic [7:0] d);
    map_result_t res;
    logic [31:0] pmask;
    logic [31:0] cmask;
    logic [31:0] bank;
    logic [12:0] pa;
    res = '0;
    pmask = (32'd1 << ((prg_log2 > PRG_LOG2_MAX) ? PRG_LOG2_MAX : prg_log2)) - 32'd1;
    cmask = (32'd1 << ((chr_log2 > CHR_LOG2_MAX) ? CHR_LOG2_MAX : chr_log2)) - 32'd1;
    case (act)
      ACT_WRITE: begin
        // writes below 0x8000 hit program RAM, which is not modeled
        if (a[15]) begin
          case ({a[15:13], a[0]})
            REG_BANK_SELECT: bank_sel = d;
            REG_BANK_DATA:   bank_regs[bank_sel[2:0]] = d;
            REG_MIRROR:      mirror_h = d[0];
            REG_IRQ_LATCH:   irq_reload = d;
            REG_IRQ_RELOAD:  scan_count = 8'h00;
            REG_IRQ_DISABLE: begin
              irq_armed = 1'b0;
              irq_flag = 1'b0;
            end
            REG_IRQ_ENABLE:  irq_armed = 1'b1;
            default: ;       // RAM protect: ignored
          endcase
        end
      end
      ACT_TICK: begin
        if (scan_count == 8'h00) scan_count = irq_reload;
        else scan_count = scan_count - 8'd1;
        if (irq_armed && scan_count == 8'h00) irq_flag = 1'b1;
      end
      ACT_PRG: begin
        if (a[15]) begin
          case (a[14:13])
            2'd1: bank = bank_regs[7];
            2'd3: bank = pmask;
            default: bank = ((a[14:13] == 2'd0) != bank_sel[6]) ? bank_regs[6]
                                                                : pmask - 32'd1;
          endcase
          res.rom_addr = 19'(((bank & pmask) << 13) | a[12:0]);
        end
      end
      default: begin
        pa = a[12:0];
        if (bank_sel[7]) pa[12] = ~pa[12];
        if (!pa[12]) bank = {bank_regs[pa[11]][7:1], pa[10]};
        else bank = bank_regs[3'd2 + pa[11:10]];
        res.rom_addr = 19'(((bank & cmask) << 10) | a[9:0]);
      end
    endcase
    res.irq = irq_flag;
    res.hmirror = mirror_h;
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------
  // Scoreboard. Both sides are sampled at the same edge in one process:
  // an accepted input transaction is predicted first, then an accepted
  // result is matched against the oldest prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    map_result_t want;
    if (!rst) begin
      if (in_valid && !in_stall)
        pending_results.push_back(map_and_update(action, addr, data));
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("result transaction with nothing outstanding");
        end else begin
          want = pending_results.pop_front();
          if (mapped_address !== want.rom_addr)
            flag_mismatch($sformatf("mapped_address %h, expected %h",
                                    mapped_address, want.rom_addr));
          if (irq_line !== want.irq)
            flag_mismatch($sformatf("irq_line %b, expected %b", irq_line, want.irq));
          if (horizontal_mirror !== want.hmirror)
            flag_mismatch($sformatf("horizontal_mirror %b, expected %b",
                                    horizontal_mirror, want.hmirror));
        end
      end
    end
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Output backpressure: stall bursts separated by free-running stretches,
  // some of them long so the pipeline also sees clean streaming.
  initial begin : stall_gen
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (no_gaps) begin
        out_stall <= 1'b0;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else if (out_stall) begin
        out_stall <= 1'b0;
        hold = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                           : $urandom_range(0, 8);
      end else begin
        hold = pick_gap();
        if (hold > 0) begin
          out_stall <= 1'b1;
          hold--;
        end
      end
    end
  end

  // Sends one input transaction; returns at the edge it is accepted, with
  // valid still high so a following call can stream back to back.
  task automatic send_item(input logic [1:0] act, input logic [15:0] a,
                           input logic [7:0] d);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    addr <= a;
    data <= d;
    do @(posedge clk); while (in_stall);
  endtask

  // Drops valid, waits for every outstanding result to be taken, then
  // idles before anything touches the size registers.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Size registers are only written with the pipeline empty.
  task automatic set_rom_sizes(input logic [2:0] prg, input logic [3:0] chr);
    cfg_write <= 1'b1;
    cfg_index <= CFG_PRG_LOG2;
    cfg_data <= {1'b0, prg};
    @(posedge clk);
    cfg_index <= CFG_CHR_LOG2;
    cfg_data <= chr;
    @(posedge clk);
    cfg_write <= 1'b0;
    prg_log2 = prg;
    chr_log2 = chr;
  endtask

  // CPU address that decodes to the given register; fill goes in the
  // don't-care bits 12..1.
  function automatic logic [15:0] reg_addr(input logic [3:0] key,
                                           input logic [11:0] fill);
    return {key[3:1], fill, key[0]};
  endfunction

  // Random traffic: mostly legal register programming (select/data pairs,
  // IRQ setup with short reload counts so the interrupt actually fires),
  // ticks and translations; a slice of raw writes anywhere in 0-0xFFFF.
  task automatic random_items(input int count);
    int n;
    int r;
    logic [3:0] key;
    logic [15:0] a;
    logic [7:0] d;
    n = 0;
    while (n < count) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_item(ACT_WRITE, 16'($urandom), 8'($urandom));
      end else if (r < 28) begin
        send_item(ACT_WRITE, reg_addr(REG_BANK_SELECT, 12'($urandom)), 8'($urandom));
        send_item(ACT_WRITE, reg_addr(REG_BANK_DATA, 12'($urandom)), 8'($urandom));
        n++;
      end else if (r < 40) begin
        case ($urandom_range(0, 6))
          0: key = REG_MIRROR;
          1: key = REG_PRG_RAM;
          2: key = REG_IRQ_LATCH;
          3: key = REG_IRQ_RELOAD;
          4: key = REG_IRQ_DISABLE;
          default: key = REG_IRQ_ENABLE;
        endcase
        d = 8'($urandom);
        if (key == REG_IRQ_LATCH && $urandom_range(0, 4) != 0) d = 8'($urandom_range(0, 6));
        send_item(ACT_WRITE, reg_addr(key, 12'($urandom)), d);
      end else if (r < 62) begin
        send_item(ACT_TICK, 16'($urandom), 8'($urandom));
      end else if (r < 82) begin
        a = 16'($urandom);
        if ($urandom_range(0, 9) != 0) a[15] = 1'b1;
        send_item(ACT_PRG, a, 8'($urandom));
      end else begin
        send_item(ACT_CHR, 16'($urandom), 8'($urandom));
      end
      n++;
    end
  endtask

  // Directed corners at the reset sizes: out-of-ROM program reads,
  // program windows with and without the swap bit, pattern wrap above
  // 0x1FFF and the pattern swap, ignored writes, mirroring, and one full
  // IRQ cycle: arm, count down to zero, acknowledge, force a reload.
  task automatic test_directed();
    send_item(ACT_PRG, 16'h0000, 8'h00);
    send_item(ACT_PRG, 16'h7FFF, 8'hFF);
    send_item(ACT_PRG, 16'h8000, 8'h00);
    send_item(ACT_PRG, 16'hFFFF, 8'h00);
    send_item(ACT_CHR, 16'hFFFF, 8'h00);
    send_item(ACT_WRITE, 16'h7FFF, 8'hFF);
    send_item(ACT_WRITE, reg_addr(REG_BANK_SELECT, 12'h000), 8'h46);
    send_item(ACT_WRITE, reg_addr(REG_BANK_DATA, 12'hFFF), 8'hFF);
    send_item(ACT_PRG, 16'h8000, 8'h00);
    send_item(ACT_PRG, 16'hC123, 8'h00);
    send_item(ACT_WRITE, reg_addr(REG_BANK_SELECT, 12'h000), 8'h82);
    send_item(ACT_WRITE, reg_addr(REG_BANK_DATA, 12'h000), 8'hAB);
    send_item(ACT_CHR, 16'h0000, 8'h00);
    send_item(ACT_CHR, 16'h1BFF, 8'h00);
    send_item(ACT_WRITE, reg_addr(REG_PRG_RAM, 12'hFFF), 8'hFF);
    send_item(ACT_WRITE, reg_addr(REG_MIRROR, 12'h000), 8'hFF);
    send_item(ACT_WRITE, reg_addr(REG_IRQ_LATCH, 12'h000), 8'h01);
    send_item(ACT_WRITE, reg_addr(REG_IRQ_ENABLE, 12'h000), 8'h00);
    send_item(ACT_TICK, 16'h0000, 8'h00);
    send_item(ACT_TICK, 16'h0000, 8'h00);
    send_item(ACT_WRITE, reg_addr(REG_IRQ_DISABLE, 12'h000), 8'h00);
    send_item(ACT_WRITE, reg_addr(REG_IRQ_RELOAD, 12'h000), 8'h00);
    send_item(ACT_TICK, 16'h0000, 8'h00);
    send_item(ACT_CHR, 16'h3FFF, 8'h00);
    drain_results();
  endtask

  // Random traffic across several ROM sizes, the saturating and the
  // undersized settings included. Each phase ends fully drained.
  task automatic test_size_sweep();
    int prg_sizes [8] = '{1, 6, 0, 7, 3, 5, 4, 2};
    int chr_sizes [8] = '{3, 8, 0, 15, 12, 4, 9, 3};
    for (int i = 0; i < 8; i++) begin
      set_rom_sizes(3'(prg_sizes[i]), 4'(chr_sizes[i]));
      random_items(125);
      drain_results();
    end
  endtask

  // Full-rate streaming: no gaps on input, no stalls on output.
  task automatic test_back_to_back();
    set_rom_sizes(3'd6, 4'd8);
    no_gaps = 1'b1;
    random_items(200);
    drain_results();
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_size_sweep();
    test_back_to_back();
    if (mismatch_count == 0) begin
      $display("bank_switch_scanline_irq_mapper_top: match");
    end else begin
      $display("bank_switch_scanline_irq_mapper_top: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10ms;
    $display("bank_switch_scanline_irq_mapper_top: mismatch");
    $finish;
  end

endmodule
